/* rtl/core/mbd_pkg.sv */
// MOV byte-stream decoder package: result type, opcode and field constants,
// and the decode helper functions used by the decoder.
// No dependencies.
`default_nettype none

package mbd_pkg;

    // Instruction forms reported in the result item.
    localparam logic [2:0] FORM_REGMEM  = 3'd0;
    localparam logic [2:0] FORM_IMM_REG = 3'd1;
    localparam logic [2:0] FORM_IMM_RM  = 3'd2;
    localparam logic [2:0] FORM_ACC     = 3'd3;
    localparam logic [2:0] FORM_UNKNOWN = 3'd4;

    // Opcode prefixes of the four MOV encodings.
    localparam logic [5:0] OP_REGMEM_PFX  = 6'b100010;
    localparam logic [3:0] OP_IMM_REG_PFX = 4'b1011;
    localparam logic [6:0] OP_IMM_RM_PFX  = 7'b1100011;
    localparam logic [5:0] OP_ACC_PFX     = 6'b101000;

    // Mod field codes and the rm code that selects a direct address.
    localparam logic [1:0] MOD_NONE   = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_DIRECT  = 3'b110;

    // Decoder phase codes.
    localparam logic [1:0] PH_OPCODE = 2'd0;
    localparam logic [1:0] PH_MODRM  = 2'd1;
    localparam logic [1:0] PH_DISP   = 2'd2;
    localparam logic [1:0] PH_DATA   = 2'd3;

    typedef struct packed {
        logic [2:0]         form;
        logic               wide;
        logic               direction;
        logic [2:0]         reg_field;
        logic [1:0]         mode;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic signed [15:0] immediate;
        logic [2:0]         length;
    } t_mbd_res;

    // Classify an opcode byte.
    function automatic logic [2:0] form_of(input logic [7:0] op);
        if (op[7:2] == OP_REGMEM_PFX) begin
            return FORM_REGMEM;
        end else if (op[7:4] == OP_IMM_REG_PFX) begin
            return FORM_IMM_REG;
        end else if (op[7:1] == OP_IMM_RM_PFX) begin
            return FORM_IMM_RM;
        end else if (op[7:2] == OP_ACC_PFX) begin
            return FORM_ACC;
        end
        return FORM_UNKNOWN;
    endfunction

    // The w bit sits at bit 3 for immediate-to-register, at bit 0 for the other known forms.
    function automatic logic wide_of(input logic [2:0] f, input logic [7:0] op);
        if (f == FORM_UNKNOWN) begin
            return 1'b0;
        end else if (f == FORM_IMM_REG) begin
            return op[3];
        end
        return op[0];
    endfunction

    // Number of displacement or address bytes that follow.
    function automatic logic [1:0] disp_len(input logic [2:0] f, input logic [7:0] m);
        if (f == FORM_ACC) begin
            return 2'd2;
        end else if (f != FORM_REGMEM && f != FORM_IMM_RM) begin
            return 2'd0;
        end else if (m[7:6] == MOD_DISP8) begin
            return 2'd1;
        end else if (m[7:6] == MOD_DISP16) begin
            return 2'd2;
        end else if (m[7:6] == MOD_NONE && m[2:0] == RM_DIRECT) begin
            return 2'd2;
        end
        return 2'd0;
    endfunction

    // Number of immediate data bytes that follow.
    function automatic logic [1:0] data_len(input logic [2:0] f, input logic [7:0] op);
        if (f == FORM_IMM_REG || f == FORM_IMM_RM) begin
            return {1'b0, 1'b1} + {1'b0, wide_of(f, op)};
        end
        return 2'd0;
    endfunction

    // Assemble a result item from the latched instruction bytes.
    function automatic t_mbd_res build_res(input logic [7:0]  op,
                                           input logic [7:0]  modrm_raw,
                                           input logic [15:0] disp_raw,
                                           input logic [15:0] data_raw);
        t_mbd_res   r;
        logic [2:0] f;
        logic       has_mrm;
        logic [7:0] m;
        logic [1:0] dl;
        logic [1:0] il;
        f       = form_of(op);
        has_mrm = (f == FORM_REGMEM) || (f == FORM_IMM_RM);
        m       = has_mrm ? modrm_raw : 8'h00;
        dl      = disp_len(f, m);
        il      = data_len(f, op);
        r.form      = f;
        r.wide      = wide_of(f, op);
        r.direction = (f == FORM_REGMEM || f == FORM_ACC) ? op[1] : 1'b0;
        if (has_mrm) begin
            r.reg_field = m[5:3];
        end else if (f == FORM_IMM_REG) begin
            r.reg_field = op[2:0];
        end else begin
            r.reg_field = 3'd0;
        end
        r.mode     = m[7:6];
        r.rm_field = m[2:0];
        if (dl == 2'd1) begin
            r.displacement = {{8{disp_raw[7]}}, disp_raw[7:0]};
        end else if (dl == 2'd2) begin
            r.displacement = disp_raw;
        end else begin
            r.displacement = 16'sd0;
        end
        if (il == 2'd1) begin
            r.immediate = {{8{data_raw[7]}}, data_raw[7:0]};
        end else if (il == 2'd2) begin
            r.immediate = data_raw;
        end else begin
            r.immediate = 16'sd0;
        end
        r.length = 3'd1 + {2'b00, has_mrm} + {1'b0, dl} + {1'b0, il};
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mbd_if.sv */
// Valid/ready channel interfaces of the MOV byte-stream decoder: the code
// byte channel and the decoded result channel. No dependencies.
`default_nettype none

interface mbd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

interface mbd_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         form;
    logic               wide;
    logic               direction;
    logic [2:0]         reg_field;
    logic [1:0]         mode;
    logic [2:0]         rm_field;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [2:0]         length;

    modport source (output valid, output form, output wide, output direction,
                    output reg_field, output mode, output rm_field,
                    output displacement, output immediate, output length,
                    input ready);
    modport sink (input valid, input form, input wide, input direction,
                  input reg_field, input mode, input rm_field,
                  input displacement, input immediate, input length,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/mbd_decode.sv */
// Phase machine of the MOV decoder: latches the opcode, mod-reg-rm,
// displacement and data bytes and builds the result item. Uses mbd_pkg.
`default_nettype none

module mbd_decode (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    output logic                  o_emit,
    output mbd_pkg::t_mbd_res     o_res
);
    import mbd_pkg::*;

    logic [1:0]  r_phase,  n_phase;
    logic [7:0]  r_op,     n_op;
    logic [7:0]  r_modrm,  n_modrm;
    logic [15:0] r_disp,   n_disp;
    logic [15:0] r_data,   n_data;
    logic [1:0]  r_left,   n_left;
    logic        n_emit;

    logic [2:0]  form_cur;
    logic [2:0]  form_new;
    logic [1:0]  il_cur;
    logic [1:0]  tot;
    logic [1:0]  diff;
    logic        hi_byte;
    logic        go_after;

    assign form_cur = form_of(r_op);
    assign il_cur   = data_len(form_cur, r_op);
    assign form_new = form_of(i_byte);

    // Next state for one code byte, and whether it completes an instruction.
    always_comb begin
        n_phase  = r_phase;
        n_op     = r_op;
        n_modrm  = r_modrm;
        n_disp   = r_disp;
        n_data   = r_data;
        n_left   = r_left;
        n_emit   = 1'b0;
        go_after = 1'b0;
        tot      = 2'd0;
        diff     = 2'd0;
        hi_byte  = 1'b0;
        case (r_phase)
            PH_MODRM: begin
                n_modrm = i_byte;
                tot     = disp_len(form_cur, i_byte);
                if (tot != 2'd0) begin
                    n_phase = PH_DISP;
                    n_left  = tot;
                end else begin
                    go_after = 1'b1;
                end
            end
            PH_DISP: begin
                tot     = disp_len(form_cur, r_modrm);
                diff    = tot - r_left;
                hi_byte = (tot > r_left) && diff[0];
                n_disp  = r_disp | (hi_byte ? {i_byte, 8'h00} : {8'h00, i_byte});
                n_left  = (r_left != 2'd0) ? r_left - 2'd1 : 2'd0;
                go_after = (n_left == 2'd0);
            end
            PH_DATA: begin
                tot     = il_cur;
                diff    = tot - r_left;
                hi_byte = (tot > r_left) && diff[0];
                n_data  = r_data | (hi_byte ? {i_byte, 8'h00} : {8'h00, i_byte});
                n_left  = (r_left != 2'd0) ? r_left - 2'd1 : 2'd0;
                n_emit  = (n_left == 2'd0);
            end
            default: begin
                n_op    = i_byte;
                n_modrm = 8'h00;
                n_disp  = 16'h0000;
                n_data  = 16'h0000;
                n_left  = 2'd0;
                if (form_new == FORM_REGMEM || form_new == FORM_IMM_RM) begin
                    n_phase = PH_MODRM;
                end else if (form_new == FORM_IMM_REG) begin
                    n_phase = PH_DATA;
                    n_left  = data_len(form_new, i_byte);
                end else if (form_new == FORM_ACC) begin
                    n_phase = PH_DISP;
                    n_left  = 2'd2;
                end else begin
                    n_emit = 1'b1;
                end
            end
        endcase

        // Mod-reg-rm or displacement finished: go on to the data bytes or finish.
        if (go_after) begin
            if (il_cur != 2'd0) begin
                n_phase = PH_DATA;
                n_left  = il_cur;
            end else begin
                n_emit = 1'b1;
            end
        end

        // A finished instruction returns to the opcode phase.
        if (n_emit) begin
            n_phase = PH_OPCODE;
            n_left  = 2'd0;
        end
    end

    assign o_emit = n_emit;
    assign o_res  = build_res(n_op, n_modrm, n_disp, n_data);

    // State update on each processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_op    <= 8'h00;
            r_modrm <= 8'h00;
            r_disp  <= 16'h0000;
            r_data  <= 16'h0000;
            r_left  <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_modrm <= n_modrm;
            r_disp  <= n_disp;
            r_data  <= n_data;
            r_left  <= n_left;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/x86_mov_byte_stream_decoder_unit.sv */
// A code byte that completes an instruction passes through the input register and
// then the result register before its result item shows.
// Throughput: one byte per cycle while the result side takes items; the
// single-cycle phase machine in mbd_decode sets this figure.
// Reset: synchronous active-low i_rst_n empties both registers and returns the
// decoder to the opcode phase with all latches cleared.
`default_nettype none

module x86_mov_byte_stream_decoder_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mbd_in_if.sink     i_in,
    mbd_out_if.source  o_out
);
    import mbd_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_out_vld;
    t_mbd_res   r_out;

    logic       dec_emit;
    t_mbd_res   dec_res;
    logic       out_free;
    logic       step;

    // The input register advances unless its result would find the output full.
    assign out_free   = !r_out_vld || o_out.ready;
    assign step       = r_in_vld && (!dec_emit || out_free);
    assign i_in.ready = !r_in_vld || step;

    mbd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_emit  (dec_emit),
        .o_res   (dec_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.code_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step && dec_emit) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && dec_emit) begin
            r_out <= dec_res;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.form         = r_out.form;
    assign o_out.wide         = r_out.wide;
    assign o_out.direction    = r_out.direction;
    assign o_out.reg_field    = r_out.reg_field;
    assign o_out.mode         = r_out.mode;
    assign o_out.rm_field     = r_out.rm_field;
    assign o_out.displacement = r_out.displacement;
    assign o_out.immediate    = r_out.immediate;
    assign o_out.length       = r_out.length;

endmodule

`default_nettype wire

/* rtl/core/mbd_chk.sv */
// Port-level checks for the MOV byte-stream decoder, bound to the top level.
// Uses mbd_pkg for the form codes.
`default_nettype none

module mbd_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [2:0]         i_form,
    input wire logic               i_wide,
    input wire logic               i_direction,
    input wire logic [2:0]         i_reg_field,
    input wire logic [1:0]         i_mode,
    input wire logic [2:0]         i_rm_field,
    input wire logic signed [15:0] i_displacement,
    input wire logic signed [15:0] i_immediate,
    input wire logic [2:0]         i_length
);
    import mbd_pkg::*;

    // A stalled result item holds its form, displacement, immediate and length.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_form)
            && $stable(i_displacement) && $stable(i_immediate) && $stable(i_length))
        else $error("stalled result item changed");

    // An unrecognized byte is a one-byte item with all other fields but rm clear.
    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_form == FORM_UNKNOWN |-> i_length == 3'd1 && !i_wide
            && !i_direction && i_reg_field == 3'd0 && i_mode == 2'd0
            && i_displacement == 16'sd0 && i_immediate == 16'sd0)
        else $error("unrecognized byte result not clean");

    // Immediate to register: length follows w, no displacement.
    a_imm_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_form == FORM_IMM_REG |-> i_length == 3'd2 + {2'b00, i_wide}
            && i_displacement == 16'sd0 && i_mode == 2'd0 && i_rm_field == 3'd0)
        else $error("immediate to register result inconsistent");

    // Accumulator form: always three bytes, no immediate and no mod-reg-rm.
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_form == FORM_ACC |-> i_length == 3'd3
            && i_immediate == 16'sd0 && i_reg_field == 3'd0 && i_mode == 2'd0)
        else $error("accumulator result inconsistent");

endmodule

bind x86_mov_byte_stream_decoder_unit mbd_chk u_mbd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_form         (o_out.form),
    .i_wide         (o_out.wide),
    .i_direction    (o_out.direction),
    .i_reg_field    (o_out.reg_field),
    .i_mode         (o_out.mode),
    .i_rm_field     (o_out.rm_field),
    .i_displacement (o_out.displacement),
    .i_immediate    (o_out.immediate),
    .i_length       (o_out.length)
);

`default_nettype wire
